[design/scalar_kalman_filter_defines.svh]
// Assertion helpers shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SKF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `SKF_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`else

`define SKF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/skf_pkg.sv]
package skf_pkg;

  // Gain is Q0.16 with one extra bit so that 1.0 is representable.
  localparam int unsigned GainW    = 17;
  localparam int unsigned SerSteps = 17;
  localparam int unsigned CntW     = 5;

  localparam logic [GainW-1:0] QOne = 17'h1_0000;

  localparam logic [30:0]        ProcNoiseRst = 31'd6554;
  localparam logic [30:0]        MeasNoiseRst = 31'd6554;
  localparam logic signed [31:0] InitEstRst   = 32'sd327680;
  localparam logic [30:0]        InitCovRst   = 31'd6554;

  typedef enum logic {
    OP_FILTER  = 1'b0,
    OP_RESTART = 1'b1
  } skf_op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_COV_OVF  = 2'd1,
    STATUS_ZERO_DEN = 2'd2,
    STATUS_EST_SAT  = 2'd3
  } skf_status_e;

  typedef enum logic [1:0] {
    CFG_PROC_NOISE = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_INIT_EST   = 2'd2,
    CFG_INIT_COV   = 2'd3
  } skf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_WB
  } skf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_unit_sts_t;

endpackage

[design/skf_if.sv]
interface skf_meas_if import skf_pkg::*; ();
  logic               valid;
  logic               ready;
  skf_op_e            op;
  logic signed [31:0] measurement;

  modport source (output valid, output op, output measurement, input ready);
  modport sink (input valid, input op, input measurement, output ready);
endinterface

interface skf_res_if import skf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic [GainW-1:0]   gain;
  logic [30:0]        covariance;
  skf_status_e        status;

  modport source (output valid, output estimate, output gain, output covariance,
                  output status, input ready);
  modport sink (input valid, input estimate, input gain, input covariance,
                input status, output ready);
endinterface

[design/skf_div.sv]
module skf_div import skf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [30:0]      dividend_i,
  input  logic [31:0]      divisor_i,
  output logic [GainW-1:0] quot_o,
  output skf_unit_sts_t    sts_o
);

  logic [32:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic [GainW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [32:0]      trial;
  logic [33:0]      diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle, MSB (the 1.0 bit) first.
  always_comb begin
    trial  = (cnt_q == '0) ? rem_q : {rem_q[31:0], 1'b0};
    diff   = {1'b0, trial} - {2'b00, den_q};
    fits   = ~diff[33];
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {2'b00, dividend_i};
      den_d  = divisor_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[32:0] : trial;
      quot_d = {quot_q[GainW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(SerSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o     = quot_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[design/skf_mac.sv]
module skf_mac import skf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] mcand_i,
  input  logic [GainW-1:0]   mplier_i,
  output logic signed [34:0] prod_o,
  output skf_unit_sts_t      sts_o
);

  logic signed [34:0] acc_q, acc_d;
  logic signed [33:0] mc_q, mc_d;
  logic [GainW-1:0]   mp_q, mp_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic signed [34:0] addend;
  logic signed [34:0] sum;
  logic               last;

  // Shift-add, multiplier LSB first. Drop one product bit per step except the
  // last, which leaves floor(mcand * mplier / 2^16).
  always_comb begin
    addend = mp_q[0] ? {mc_q[33], mc_q} : '0;
    sum    = acc_q + addend;
    last   = (cnt_q == CntW'(SerSteps - 1));
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      mc_d   = mcand_i;
      mp_d   = mplier_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = last ? sum : (sum >>> 1);
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign prod_o     = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[design/scalar_kalman_filter.sv]
// Channel   Dir  Payload                                   Transfer
// meas_i    in   op, measurement (Q16.16)                  valid && ready
// res_o     out  estimate, gain, covariance, status        valid && ready
// cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i high
//
// A filter item goes from its transfer to the output register through the predict
// state, 17 divider steps and 17 multiplier steps (both products side by side),
// a done strobe after each unit and the write-back state. Restart items and items
// that fault before the divide go from predict straight to write-back.
// One item is in flight at a time; the next transfer is taken the cycle after
// write-back, and write-back holds while the output register is still full.
// Reset is asynchronous, active low, and loads the state from the defaults.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter import skf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  skf_meas_if.sink    meas_i,
  skf_res_if.source   res_o
);

  skf_state_e state_q, state_d;

  // configuration registers
  logic [30:0]        q_q, r_q, p0_q;
  logic signed [31:0] x0_q;

  // filter state
  logic signed [31:0] x_q, x_d;
  logic [30:0]        p_q, p_d;
  logic [GainW-1:0]   k_q, k_d;
  skf_status_e        st_d;

  // per-item working registers
  skf_op_e            op_q;
  logic signed [31:0] z_q;
  logic [31:0]        pp_q;
  logic signed [32:0] e_q;
  skf_status_e        stat_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_x_q;
  logic [GainW-1:0]   out_k_q;
  logic [30:0]        out_p_q;
  skf_status_e        out_st_q;

  // predict
  logic [31:0]        pp;
  logic [31:0]        den;
  logic               cov_ovf;
  logic               den_zero;
  logic signed [32:0] err;
  skf_status_e        prep_stat;

  // write-back
  logic signed [34:0] nx;
  logic               est_sat;
  logic signed [31:0] est_clamp;

  // handshakes and unit control
  logic accept;
  logic div_start;
  logic mac_start;
  logic wb_fire;

  logic [GainW-1:0]   div_quot;
  skf_unit_sts_t      div_sts;
  logic signed [34:0] prod_e, prod_p;
  skf_unit_sts_t      mac_e_sts, mac_p_sts;

  //--------------------------------------------------------------------------
  // Configuration writes; out-of-range bits are dropped.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q  <= ProcNoiseRst;
      r_q  <= MeasNoiseRst;
      x0_q <= InitEstRst;
      p0_q <= InitCovRst;
    end else if (cfg_we_i) begin
      case (skf_cfg_e'(cfg_idx_i))
        CFG_PROC_NOISE: q_q  <= cfg_data_i[30:0];
        CFG_MEAS_NOISE: r_q  <= cfg_data_i[30:0];
        CFG_INIT_EST:   x0_q <= cfg_data_i;
        CFG_INIT_COV:   p0_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Predict: p' = p + q, denominator p' + r, innovation z - x.
  // Overflow of p' shows up as bit 31; the denominator only matters without it.
  //--------------------------------------------------------------------------
  always_comb begin
    pp       = {1'b0, p_q} + {1'b0, q_q};
    cov_ovf  = pp[31];
    den      = pp + {1'b0, r_q};
    den_zero = (den == '0);
    err      = {z_q[31], z_q} - {x_q[31], x_q};
    if (op_q == OP_RESTART) begin
      prep_stat = STATUS_OK;
    end else if (cov_ovf) begin
      prep_stat = STATUS_COV_OVF;
    end else if (den_zero) begin
      prep_stat = STATUS_ZERO_DEN;
    end else begin
      prep_stat = STATUS_OK;
    end
  end

  //--------------------------------------------------------------------------
  // Serial units: gain divider, then k*(z-x) and p'*(1-k) side by side.
  //--------------------------------------------------------------------------
  skf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pp[30:0]),
    .divisor_i  (den),
    .quot_o     (div_quot),
    .sts_o      (div_sts)
  );

  skf_mac u_mac_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .mcand_i  ({e_q[32], e_q}),
    .mplier_i (div_quot),
    .prod_o   (prod_e),
    .sts_o    (mac_e_sts)
  );

  skf_mac u_mac_cov (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .mcand_i  ({3'b000, pp_q[30:0]}),
    .mplier_i (QOne - div_quot),
    .prod_o   (prod_p),
    .sts_o    (mac_p_sts)
  );

  //--------------------------------------------------------------------------
  // Write-back: pick the new state for the item's outcome.
  //--------------------------------------------------------------------------
  always_comb begin
    nx        = {{3{x_q[31]}}, x_q} + prod_e;
    est_sat   = (nx[34:31] != {4{nx[34]}});
    est_clamp = nx[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    x_d       = x_q;
    p_d       = p_q;
    k_d       = k_q;
    st_d      = stat_q;
    if (op_q == OP_RESTART) begin
      x_d  = x0_q;
      p_d  = p0_q;
      k_d  = '0;
      st_d = STATUS_OK;
    end else begin
      case (stat_q)
        STATUS_COV_OVF: ;
        STATUS_ZERO_DEN: p_d = pp_q[30:0];
        default: begin
          k_d = div_quot;
          if (est_sat) begin
            x_d  = est_clamp;
            p_d  = pp_q[30:0];
            st_d = STATUS_EST_SAT;
          end else begin
            x_d = nx[31:0];
            p_d = prod_p[30:0];
          end
        end
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_PREP;
      ST_PREP: state_d = div_start ? ST_DIV : ST_WB;
      ST_DIV:  if (div_sts.done) state_d = ST_MUL;
      ST_MUL:  if (mac_e_sts.done) state_d = ST_WB;
      ST_WB:   if (wb_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    mac_start = 1'b0;
    wb_fire   = 1'b0;
    case (state_q)
      ST_PREP: div_start = (op_q == OP_FILTER) && !cov_ovf && !den_zero;
      ST_DIV:  mac_start = div_sts.done;
      // hold the result while the output register is still full
      ST_WB:   wb_fire = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign meas_i.ready = (state_q == ST_IDLE);
  assign accept       = meas_i.valid && meas_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= InitEstRst;
      p_q         <= InitCovRst;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
        x_q         <= x_d;
        p_q         <= p_d;
        k_q         <= k_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= meas_i.op;
      z_q  <= meas_i.measurement;
    end
    if (state_q == ST_PREP) begin
      pp_q   <= pp;
      e_q    <= err;
      stat_q <= prep_stat;
    end
    if (wb_fire) begin
      out_x_q  <= x_d;
      out_k_q  <= k_d;
      out_p_q  <= p_d;
      out_st_q <= st_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.estimate   = out_x_q;
  assign res_o.gain       = out_k_q;
  assign res_o.covariance = out_p_q;
  assign res_o.status     = out_st_q;

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  `SKF_ASSERT_NEXT(a_accept_to_prep, clk_i, rst_ni, accept, state_q == ST_PREP,
                   "transfer did not start predict")
  `SKF_ASSERT(a_div_in_div, clk_i, rst_ni,
              (div_sts.busy || div_sts.done) |-> (state_q == ST_DIV),
              "divider active outside divide phase")
  `SKF_ASSERT(a_mac_lockstep, clk_i, rst_ni, mac_e_sts == mac_p_sts,
              "multipliers out of step")
  `SKF_ASSERT(a_gain_bounded, clk_i, rst_ni, k_q <= QOne, "gain above one")
  `SKF_ASSERT(a_no_est_sat, clk_i, rst_ni, out_valid_q |-> (out_st_q != STATUS_EST_SAT),
              "estimate left the span of x and z")

endmodule
